@@ src/iswc_pkg.sv @@
`default_nettype none

package iswc_pkg;

    localparam int AXES        = 3;
    localparam int PORT_AXES   = 3;

    localparam int SAMPLE_W    = 16;
    localparam int LIMIT_W     = 16;
    localparam int FILL_W      = 10;
    localparam int RUN_W       = 16;
    localparam int BEAT_W      = 8;
    localparam int MODE_W      = 2;
    localparam int SEND_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [SAMPLE_W-1:0] AXIS_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] AXIS_MIN = 16'sh8000;

    localparam logic [LIMIT_W-1:0] STILL_PEAK_LIMIT_RST   = 16'd143;
    localparam logic [FILL_W-1:0]  BLOCK_LENGTH_RST       = 10'd166;
    localparam logic [RUN_W-1:0]   IDLE_BLOCK_COUNT_RST   = 16'd300;
    localparam logic [LIMIT_W-1:0] WAKE_GYRO_LIMIT_RST    = 16'd143;
    localparam logic [LIMIT_W-1:0] WAKE_ACCEL_LIMIT_RST   = 16'd820;
    localparam logic [BEAT_W-1:0]  HEARTBEAT_INTERVAL_RST = 8'd13;

    localparam logic [SEND_W-1:0] SEND_NONE = 2'd0;
    localparam logic [SEND_W-1:0] SEND_ONE  = 2'd1;
    localparam logic [SEND_W-1:0] SEND_TWO  = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STILL_PEAK_LIMIT   = 3'd0,
        CFG_BLOCK_LENGTH       = 3'd1,
        CFG_IDLE_BLOCK_COUNT   = 3'd2,
        CFG_WAKE_GYRO_LIMIT    = 3'd3,
        CFG_WAKE_ACCEL_LIMIT   = 3'd4,
        CFG_HEARTBEAT_INTERVAL = 3'd5
    } cfg_index_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic track;
        logic clear;
        logic latch_rest;
        logic follow_rest;
    } lane_ctrl_t;

    typedef struct packed {
        logic peak_over;
        logic moved;
    } lane_flags_t;

    typedef struct packed {
        logic [MODE_W-1:0] op_mode;
        logic [SEND_W-1:0] send_count;
        logic              entered_idle;
        logic              woke_up;
        logic              sensor_error;
    } result_t;

endpackage

`default_nettype wire

@@ src/imu_stillness_idle_wake_controller_core.sv @@
`default_nettype none

// Channel  Handshake              Beat
// input    in_valid / in_stall    gyro_x..z, accel_x..z, wired_link, read_failed
// output   out_valid / out_stall  op_mode, send_count, entered_idle, woke_up, sensor_error
// config   cfg_we                 cfg_index, cfg_data
//
// One beat per cycle in while in_stall is low, one result beat in the cycle after it is accepted.
// Each axis lane and the mode/counter merge handle a sample combinationally, with their state registered.
// in_stall is high only while a result beat sits in the output register stalled.
// rst_n clears mode, counters, block extremes and rest values at once.

module imu_stillness_idle_wake_controller_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  gyro_x,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  gyro_y,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  gyro_z,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  accel_x,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  accel_y,
    input  wire signed [iswc_pkg::SAMPLE_W-1:0]  accel_z,
    input  wire                                  wired_link,
    input  wire                                  read_failed,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [iswc_pkg::MODE_W-1:0]          op_mode,
    output logic [iswc_pkg::SEND_W-1:0]          send_count,
    output logic                                 entered_idle,
    output logic                                 woke_up,
    output logic                                 sensor_error,
    input  wire                                  cfg_we,
    input  wire [iswc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [iswc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [iswc_pkg::LIMIT_W-1:0] still_peak_limit_reg;
    logic [iswc_pkg::FILL_W-1:0]  block_length_reg;
    logic [iswc_pkg::RUN_W-1:0]   idle_block_count_reg;
    logic [iswc_pkg::LIMIT_W-1:0] wake_gyro_limit_reg;
    logic [iswc_pkg::LIMIT_W-1:0] wake_accel_limit_reg;
    logic [iswc_pkg::BEAT_W-1:0]  heartbeat_interval_reg;

    logic                  out_valid_reg, out_valid_next;
    iswc_pkg::result_t     out_reg;
    iswc_pkg::result_t     res;
    iswc_pkg::lane_ctrl_t  ctrl;
    iswc_pkg::lane_flags_t flags [iswc_pkg::AXES];
    iswc_pkg::sample_t     gyro_in  [iswc_pkg::PORT_AXES];
    iswc_pkg::sample_t     accel_in [iswc_pkg::PORT_AXES];
    logic                  accept;

    assign gyro_in[0]  = gyro_x;
    assign gyro_in[1]  = gyro_y;
    assign gyro_in[2]  = gyro_z;
    assign accel_in[0] = accel_x;
    assign accel_in[1] = accel_y;
    assign accel_in[2] = accel_z;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_peak_limit_reg   <= iswc_pkg::STILL_PEAK_LIMIT_RST;
            block_length_reg       <= iswc_pkg::BLOCK_LENGTH_RST;
            idle_block_count_reg   <= iswc_pkg::IDLE_BLOCK_COUNT_RST;
            wake_gyro_limit_reg    <= iswc_pkg::WAKE_GYRO_LIMIT_RST;
            wake_accel_limit_reg   <= iswc_pkg::WAKE_ACCEL_LIMIT_RST;
            heartbeat_interval_reg <= iswc_pkg::HEARTBEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iswc_pkg::CFG_STILL_PEAK_LIMIT:
                    still_peak_limit_reg <= cfg_data[iswc_pkg::LIMIT_W-1:0];
                iswc_pkg::CFG_BLOCK_LENGTH:
                    block_length_reg <= cfg_data[iswc_pkg::FILL_W-1:0];
                iswc_pkg::CFG_IDLE_BLOCK_COUNT:
                    idle_block_count_reg <= cfg_data[iswc_pkg::RUN_W-1:0];
                iswc_pkg::CFG_WAKE_GYRO_LIMIT:
                    wake_gyro_limit_reg <= cfg_data[iswc_pkg::LIMIT_W-1:0];
                iswc_pkg::CFG_WAKE_ACCEL_LIMIT:
                    wake_accel_limit_reg <= cfg_data[iswc_pkg::LIMIT_W-1:0];
                iswc_pkg::CFG_HEARTBEAT_INTERVAL:
                    heartbeat_interval_reg <= cfg_data[iswc_pkg::BEAT_W-1:0];
                default:
                    still_peak_limit_reg <= still_peak_limit_reg;
            endcase
        end
    end

    for (genvar i = 0; i < iswc_pkg::AXES; i++)
    begin : g_lane
        iswc_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .gyro             (gyro_in[i]),
            .accel            (accel_in[i]),
            .ctrl             (ctrl),
            .still_peak_limit (still_peak_limit_reg),
            .wake_gyro_limit  (wake_gyro_limit_reg),
            .wake_accel_limit (wake_accel_limit_reg),
            .flags            (flags[i])
        );
    end

    iswc_merge u_merge (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (accept),
        .wired_link         (wired_link),
        .read_failed        (read_failed),
        .flags              (flags),
        .block_length       (block_length_reg),
        .idle_block_count   (idle_block_count_reg),
        .heartbeat_interval (heartbeat_interval_reg),
        .ctrl               (ctrl),
        .res                (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign op_mode      = out_reg.op_mode;
    assign send_count   = out_reg.send_count;
    assign entered_idle = out_reg.entered_idle;
    assign woke_up      = out_reg.woke_up;
    assign sensor_error = out_reg.sensor_error;

    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sensor_error |-> out_reg.send_count == iswc_pkg::SEND_NONE)
        else $error("failed read requested a packet");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result beat changed");

endmodule

`default_nettype wire

@@ src/iswc_lane.sv @@
`default_nettype none

module iswc_lane (
    input  wire                              clk,
    input  wire                              rst_n,
    input  iswc_pkg::sample_t                gyro,
    input  iswc_pkg::sample_t                accel,
    input  iswc_pkg::lane_ctrl_t             ctrl,
    input  wire [iswc_pkg::LIMIT_W-1:0]      still_peak_limit,
    input  wire [iswc_pkg::LIMIT_W-1:0]      wake_gyro_limit,
    input  wire [iswc_pkg::LIMIT_W-1:0]      wake_accel_limit,
    output iswc_pkg::lane_flags_t            flags
);

    iswc_pkg::sample_t low_reg, low_next;
    iswc_pkg::sample_t high_reg, high_next;
    iswc_pkg::sample_t rest_gyro_reg, rest_gyro_next;
    iswc_pkg::sample_t rest_accel_reg, rest_accel_next;

    iswc_pkg::sample_t                    low_upd;
    iswc_pkg::sample_t                    high_upd;
    logic signed [iswc_pkg::SAMPLE_W:0]   span;
    logic signed [iswc_pkg::SAMPLE_W:0]   gdiff;
    logic signed [iswc_pkg::SAMPLE_W:0]   adiff;
    logic        [iswc_pkg::SAMPLE_W:0]   gabs;
    logic        [iswc_pkg::SAMPLE_W:0]   aabs;
    logic signed [iswc_pkg::SAMPLE_W:0]   gstep;

    always_comb
    begin
        low_upd  = (gyro < low_reg)  ? gyro : low_reg;
        high_upd = (gyro > high_reg) ? gyro : high_reg;
        span     = (iswc_pkg::SAMPLE_W+1)'(high_upd) - (iswc_pkg::SAMPLE_W+1)'(low_upd);

        gdiff = (iswc_pkg::SAMPLE_W+1)'(gyro)  - (iswc_pkg::SAMPLE_W+1)'(rest_gyro_reg);
        adiff = (iswc_pkg::SAMPLE_W+1)'(accel) - (iswc_pkg::SAMPLE_W+1)'(rest_accel_reg);
        gabs  = gdiff[iswc_pkg::SAMPLE_W] ? (iswc_pkg::SAMPLE_W+1)'(-gdiff) : gdiff;
        aabs  = adiff[iswc_pkg::SAMPLE_W] ? (iswc_pkg::SAMPLE_W+1)'(-adiff) : adiff;

        // truncate toward zero
        gstep = gdiff[iswc_pkg::SAMPLE_W] ? ((gdiff + 17'sd7) >>> 3) : (gdiff >>> 3);

        flags.peak_over = span > $signed({1'b0, still_peak_limit});
        flags.moved     = (gabs[iswc_pkg::SAMPLE_W-1:0] > wake_gyro_limit)
                       || (aabs[iswc_pkg::SAMPLE_W-1:0] > wake_accel_limit);

        low_next        = low_reg;
        high_next       = high_reg;
        rest_gyro_next  = rest_gyro_reg;
        rest_accel_next = rest_accel_reg;

        if (ctrl.clear)
        begin
            low_next  = iswc_pkg::AXIS_MAX;
            high_next = iswc_pkg::AXIS_MIN;
        end
        else if (ctrl.track)
        begin
            low_next  = low_upd;
            high_next = high_upd;
        end

        if (ctrl.latch_rest)
        begin
            rest_gyro_next  = gyro;
            rest_accel_next = accel;
        end
        else if (ctrl.follow_rest)
        begin
            rest_gyro_next = rest_gyro_reg + $signed(gstep[iswc_pkg::SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= iswc_pkg::AXIS_MAX;
            high_reg       <= iswc_pkg::AXIS_MIN;
            rest_gyro_reg  <= '0;
            rest_accel_reg <= '0;
        end
        else
        begin
            low_reg        <= low_next;
            high_reg       <= high_next;
            rest_gyro_reg  <= rest_gyro_next;
            rest_accel_reg <= rest_accel_next;
        end
    end

endmodule

`default_nettype wire

@@ src/iswc_merge.sv @@
`default_nettype none

module iswc_merge (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               step,
    input  wire                               wired_link,
    input  wire                               read_failed,
    input  iswc_pkg::lane_flags_t             flags [iswc_pkg::AXES],
    input  wire [iswc_pkg::FILL_W-1:0]        block_length,
    input  wire [iswc_pkg::RUN_W-1:0]         idle_block_count,
    input  wire [iswc_pkg::BEAT_W-1:0]        heartbeat_interval,
    output iswc_pkg::lane_ctrl_t              ctrl,
    output iswc_pkg::result_t                 res
);

    typedef enum logic [iswc_pkg::MODE_W-1:0] {
        ST_RADIO = 2'd0,
        ST_IDLE  = 2'd1,
        ST_WIRED = 2'd2
    } state_t;

    state_t                        state_reg, state_next, state_link;
    logic [iswc_pkg::FILL_W-1:0]   fill_reg, fill_next, fill_inc;
    logic [iswc_pkg::RUN_W-1:0]    run_reg, run_next, run_link, run_sat, run_blk;
    logic [iswc_pkg::BEAT_W-1:0]   beat_reg, beat_next, beat_inc;
    logic                          ok;
    logic                          any_moved;
    logic                          any_over;
    logic                          blk_end;
    logic                          enter;
    logic                          beat_hit;

    always_comb
    begin
        any_moved = 1'b0;
        any_over  = 1'b0;
        for (int i = 0; i < iswc_pkg::AXES; i++)
        begin
            any_moved = any_moved | flags[i].moved;
            any_over  = any_over  | flags[i].peak_over;
        end

        state_link = state_reg;
        run_link   = run_reg;
        if (wired_link && state_reg != ST_WIRED)
        begin
            state_link = ST_WIRED;
        end
        else if (!wired_link && state_reg == ST_WIRED)
        begin
            state_link = ST_RADIO;
            run_link   = '0;
        end

        ok       = step && !read_failed;
        fill_inc = fill_reg + 1'b1;
        blk_end  = fill_inc >= block_length;
        run_sat  = (run_link == '1) ? run_link : run_link + 1'b1;
        run_blk  = any_over ? '0 : run_sat;
        enter    = run_blk >= idle_block_count;
        beat_inc = beat_reg + 1'b1;
        beat_hit = beat_inc >= heartbeat_interval;

        state_next = state_link;
        fill_next  = fill_reg;
        run_next   = run_link;
        beat_next  = beat_reg;
        ctrl       = '0;

        res.send_count   = iswc_pkg::SEND_NONE;
        res.entered_idle = 1'b0;
        res.woke_up      = 1'b0;
        res.sensor_error = read_failed;

        if (ok)
        begin
            case (state_link)
                ST_IDLE:
                begin
                    ctrl.follow_rest = 1'b1;
                    if (any_moved)
                    begin
                        state_next     = ST_RADIO;
                        run_next       = '0;
                        fill_next      = '0;
                        ctrl.clear     = 1'b1;
                        res.send_count = iswc_pkg::SEND_ONE;
                        res.woke_up    = 1'b1;
                    end
                    else if (beat_hit)
                    begin
                        beat_next      = '0;
                        res.send_count = iswc_pkg::SEND_ONE;
                    end
                    else
                    begin
                        beat_next = beat_inc;
                    end
                end
                ST_RADIO:
                begin
                    ctrl.track     = 1'b1;
                    res.send_count = iswc_pkg::SEND_ONE;
                    fill_next      = fill_inc;
                    if (blk_end)
                    begin
                        ctrl.clear = 1'b1;
                        fill_next  = '0;
                        run_next   = run_blk;
                        if (enter)
                        begin
                            ctrl.latch_rest  = 1'b1;
                            beat_next        = '0;
                            state_next       = ST_IDLE;
                            res.send_count   = iswc_pkg::SEND_TWO;
                            res.entered_idle = 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_next = state_link;
                end
            endcase
        end

        res.op_mode = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RADIO;
            fill_reg  <= '0;
            run_reg   <= '0;
            beat_reg  <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            run_reg   <= run_next;
            beat_reg  <= beat_next;
        end
    end

    a_enter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.entered_idle |=> state_reg == ST_IDLE)
        else $error("entered idle but mode is not idle");

    a_wired: assert property (@(posedge clk) disable iff (!rst_n)
        step && wired_link |=> state_reg == ST_WIRED)
        else $error("wired link did not force wired mode");

    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && read_failed |=> $stable(fill_reg) && $stable(beat_reg))
        else $error("failed read changed block or heartbeat count");

    a_wake_radio: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.woke_up |=> state_reg == ST_RADIO && run_reg == '0)
        else $error("wake did not return to radio mode");

endmodule

`default_nettype wire
